[rtl/ubxp_pkg.sv]
// Package for the UBX NAV-POSLLH frame parser.
// Holds the frame offsets, the default frame limit and the checksum control type.
// No dependencies.
package ubxp_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 255;

    // Fixed byte offsets inside a UBX frame.
    localparam int HDR_FIRST  = 2;
    localparam int HDR_LAST   = 5;
    localparam int WORD_FIRST = 6;
    localparam int WORD_LAST  = 33;
    localparam int NUM_HDR    = 4;
    localparam int NUM_WORDS  = 7;

    // Summing starts once the byte two positions back lies at offset 2.
    localparam int FOLD_FIRST = 4;
    // A frame needs at least four bytes to carry a valid checksum.
    localparam int CHECK_FIRST = 3;

    typedef struct packed {
        logic step;     // a byte is consumed this cycle
        logic last;     // it is the last byte of the frame
        logic fold;     // the delayed byte enters the sums
        logic long_enough;
    } ubxp_ck_ctrl_t;

endpackage

[rtl/ubxp_if.sv]
// Stream interfaces for the UBX NAV-POSLLH frame parser: frame bytes in, results out.
// Each carries valid, ready and the payload. No dependencies.
interface ubxp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface ubxp_result_if;
    logic               valid;
    logic               ready;
    logic               checksum_ok;
    logic [7:0]         msg_class;
    logic [7:0]         msg_id;
    logic [15:0]        payload_length;
    logic [31:0]        time_of_week_ms;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] ellipsoid_height;
    logic signed [31:0] sea_level_height;
    logic [31:0]        horiz_accuracy;
    logic [31:0]        vert_accuracy;

    modport source (output valid, output checksum_ok, output msg_class, output msg_id,
                    output payload_length, output time_of_week_ms, output longitude,
                    output latitude, output ellipsoid_height, output sea_level_height,
                    output horiz_accuracy, output vert_accuracy, input ready);
    modport sink   (input valid, input checksum_ok, input msg_class, input msg_id,
                    input payload_length, input time_of_week_ms, input longitude,
                    input latitude, input ellipsoid_height, input sea_level_height,
                    input horiz_accuracy, input vert_accuracy, output ready);
endinterface

[rtl/ubxp_fletcher.sv]
// 8-bit Fletcher checksum unit with its two-byte delay line.
// Depends on ubxp_pkg for the control struct.
module ubxp_fletcher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ubxp_pkg::ubxp_ck_ctrl_t ctrl,
    input  logic [7:0]             rx_byte,
    output logic                   checksum_ok
);
    import ubxp_pkg::*;

    logic [7:0] sum_a_reg, sum_b_reg;
    logic [7:0] dly0_reg, dly1_reg;
    logic [7:0] sum_a_next, sum_b_next;

    always_comb
    begin
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        if (ctrl.fold)
        begin
            sum_a_next = sum_a_reg + dly1_reg;
            sum_b_next = sum_b_reg + sum_a_next;
        end
    end

    // The last two bytes are the checksum: the older sits in the delay line.
    assign checksum_ok = ctrl.long_enough && (sum_a_next == dly0_reg)
                         && (sum_b_next == rx_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            dly0_reg  <= '0;
            dly1_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.last)
            begin
                sum_a_reg <= '0;
                sum_b_reg <= '0;
                dly0_reg  <= '0;
                dly1_reg  <= '0;
            end
            else
            begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
                dly1_reg  <= dly0_reg;
                dly0_reg  <= rx_byte;
            end
        end
    end
endmodule

[rtl/ubx_posllh_frame_parser.sv]
// UBX NAV-POSLLH frame parser: one frame byte per beat, one result per frame.
// The last byte passes the byte stage and the result register before the result is valid.
// Throughput: one byte per cycle, but a frame's last byte waits while a result is untaken.
// A byte stage and a result register part the two sides, so bytes keep flowing while
// a result waits. Reset (rst_n low, asynchronous) clears the byte count, sums and captures.
module ubx_posllh_frame_parser #(
    parameter int MAX_FRAME_BYTES = ubxp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ubxp_byte_if.sink    frame,
    ubxp_result_if.source result
);
    import ubxp_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int WIDX_W = IDX_W - 2;

    // Byte stage.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       step;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       hdr_reg  [NUM_HDR];
    logic [7:0]       hdr_cur  [NUM_HDR];
    logic [31:0]      word_reg [NUM_WORDS];
    logic [31:0]      word_cur [NUM_WORDS];

    logic [IDX_W-1:0]  rel;
    logic [WIDX_W-1:0] widx;
    logic [1:0]        lane;
    logic              in_hdr, in_word;

    ubxp_ck_ctrl_t ck_ctrl;
    logic          ck_ok;

    logic out_valid_reg, out_valid_next;

    assign step = s1_valid_reg && (!s1_end_reg || !out_valid_reg || result.ready);
    assign frame.ready = !s1_valid_reg || step;
    assign s1_valid_next = (frame.valid && frame.ready) ? 1'b1 : (step ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            s1_byte_reg <= frame.rx_byte;
            s1_end_reg  <= frame.frame_end;
        end
    end

    // Checksum unit.
    assign ck_ctrl.step        = step;
    assign ck_ctrl.last        = s1_end_reg;
    assign ck_ctrl.fold        = idx_reg >= IDX_W'(FOLD_FIRST);
    assign ck_ctrl.long_enough = idx_reg >= IDX_W'(CHECK_FIRST);

    ubxp_fletcher u_fletcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ck_ctrl),
        .rx_byte     (s1_byte_reg),
        .checksum_ok (ck_ok)
    );

    // Field capture, including the byte being consumed now.
    assign in_hdr  = (idx_reg >= IDX_W'(HDR_FIRST)) && (idx_reg <= IDX_W'(HDR_LAST));
    assign in_word = (idx_reg >= IDX_W'(WORD_FIRST)) && (idx_reg <= IDX_W'(WORD_LAST));
    assign rel     = idx_reg - IDX_W'(WORD_FIRST);
    assign widx    = rel[IDX_W-1:2];
    assign lane    = rel[1:0];

    always_comb
    begin
        for (int h = 0; h < NUM_HDR; h++)
        begin
            hdr_cur[h] = hdr_reg[h];
            if (in_hdr && (idx_reg == IDX_W'(HDR_FIRST + h)))
                hdr_cur[h] = s1_byte_reg;
        end
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            word_cur[w] = word_reg[w];
            for (int l = 0; l < 4; l++)
            begin
                if (in_word && (widx == WIDX_W'(w)) && (lane == 2'(l)))
                    word_cur[w][l*8 +: 8] = s1_byte_reg;
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (step)
        begin
            if (s1_end_reg)
                idx_next = '0;
            else if (idx_reg < IDX_W'(MAX_FRAME_BYTES))
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int h = 0; h < NUM_HDR; h++)
                hdr_reg[h] <= '0;
            for (int w = 0; w < NUM_WORDS; w++)
                word_reg[w] <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (step)
            begin
                for (int h = 0; h < NUM_HDR; h++)
                    hdr_reg[h] <= s1_end_reg ? 8'd0 : hdr_cur[h];
                for (int w = 0; w < NUM_WORDS; w++)
                    word_reg[w] <= s1_end_reg ? 32'd0 : word_cur[w];
            end
        end
    end

    // Result register.
    assign out_valid_next = (step && s1_end_reg) ? 1'b1
                          : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_end_reg)
        begin
            result.checksum_ok      <= ck_ok;
            result.msg_class        <= hdr_cur[0];
            result.msg_id           <= hdr_cur[1];
            result.payload_length   <= {hdr_cur[3], hdr_cur[2]};
            result.time_of_week_ms  <= word_cur[0];
            result.longitude        <= $signed(word_cur[1]);
            result.latitude         <= $signed(word_cur[2]);
            result.ellipsoid_height <= $signed(word_cur[3]);
            result.sea_level_height <= $signed(word_cur[4]);
            result.horiz_accuracy   <= word_cur[5];
            result.vert_accuracy    <= word_cur[6];
        end
    end

    assign result.valid = out_valid_reg;
endmodule

[rtl/ubxp_checker.sv]
// Port-level checker for the UBX NAV-POSLLH frame parser, bound to the top level.
// Depends only on the top level's ports.
module ubxp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ok,
    input logic [31:0] out_tow
);
    // Frames whose last byte was accepted but whose result is not yet taken.
    logic [1:0] pending_reg, pending_next;
    logic       inc, dec;

    assign inc = in_valid && in_ready && in_end;
    assign dec = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (inc && !dec)
            pending_next = pending_reg + 2'd1;
        else if (dec && !inc)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_tow))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without a finished frame");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more frames in flight than the byte stage and result register hold");
endmodule

bind ubx_posllh_frame_parser ubxp_checker u_ubxp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .in_end    (frame.frame_end),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_ok    (result.checksum_ok),
    .out_tow   (result.time_of_week_ms)
);

[dv/ubx_posllh_frame_parser_tb.sv]
// Self-checking testbench for the UBX NAV-POSLLH frame parser.
// Depends on ubxp_pkg, the ubxp_byte_if and ubxp_result_if interfaces and the parser RTL.
// Frames stream in under random idling and result stalls, and are checked against a local model.
module ubx_posllh_frame_parser_tb;

    import ubxp_pkg::*;

    localparam int FRAME_CAP      = MAX_FRAME_BYTES_DEF;
    localparam int RANDOM_BYTES   = 1050;
    localparam int MIN_FRAMES     = 40;
    localparam int PHASE_BYTES    = 160;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_PRINTED    = 100;
    localparam logic [7:0] SYNC_1 = 8'hB5;
    localparam logic [7:0] SYNC_2 = 8'h62;
    localparam logic [7:0] CLS_NAV = 8'h01;
    localparam logic [7:0] ID_POSLLH = 8'h02;
    localparam logic [7:0] POSLLH_LEN = 8'd28;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
        logic       hold;       // wait for all results before this beat
    } byte_beat_t;

    typedef struct packed {
        logic               checksum_ok;
        logic [7:0]         msg_class;
        logic [7:0]         msg_id;
        logic [15:0]        payload_length;
        logic [31:0]        time_of_week_ms;
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic signed [31:0] ellipsoid_height;
        logic signed [31:0] sea_level_height;
        logic [31:0]        horiz_accuracy;
        logic [31:0]        vert_accuracy;
    } posllh_t;

    logic clk;
    logic rst_n;

    ubxp_byte_if   frame ();
    ubxp_result_if result ();

    ubx_posllh_frame_parser #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame),
        .result(result)
    );

    byte_beat_t tx_q[$];
    posllh_t    posllh_expected_q[$];
    logic [7:0] frame_buf[$];

    int bytes_sent;
    int traffic_phase;
    int results_predicted;
    int results_seen;
    int mismatches;

    // Parser model state.
    int unsigned frame_pos;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [7:0]  lag_bytes[2];
    logic [7:0]  hdr_bytes[NUM_HDR];
    logic [31:0] pos_words[NUM_WORDS];

    function automatic int src_idle_pct(input int phase);
        return (phase == 1) ? 66 : (phase == 3) ? 9 : 0;
    endfunction

    function automatic int sink_stall_pct(input int phase);
        return (phase == 2) ? 66 : (phase == 3) ? 9 : 0;
    endfunction

    task automatic clear_parse_state();
        frame_pos    = 0;
        ck_a         = '0;
        ck_b         = '0;
        lag_bytes[0] = '0;
        lag_bytes[1] = '0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        foreach (pos_words[i]) pos_words[i] = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned rel;
        posllh_t     r;
        pos = frame_pos;
        // The byte two positions back enters the sums once it lies at offset 2.
        if (pos >= FOLD_FIRST) begin
            ck_a = ck_a + lag_bytes[1];
            ck_b = ck_b + ck_a;
        end
        if (pos >= HDR_FIRST && pos <= HDR_LAST) begin
            hdr_bytes[pos - HDR_FIRST] = b;
        end
        else if (pos >= WORD_FIRST && pos <= WORD_LAST) begin
            rel = pos - WORD_FIRST;
            pos_words[rel / 4][8 * (rel % 4) +: 8] = b;
        end
        if (last) begin
            r.checksum_ok      = (pos >= CHECK_FIRST) && (ck_a == lag_bytes[0]) && (ck_b == b);
            r.msg_class        = hdr_bytes[0];
            r.msg_id           = hdr_bytes[1];
            r.payload_length   = {hdr_bytes[3], hdr_bytes[2]};
            r.time_of_week_ms  = pos_words[0];
            r.longitude        = pos_words[1];
            r.latitude         = pos_words[2];
            r.ellipsoid_height = pos_words[3];
            r.sea_level_height = pos_words[4];
            r.horiz_accuracy   = pos_words[5];
            r.vert_accuracy    = pos_words[6];
            posllh_expected_q.push_back(r);
            results_predicted = results_predicted + 1;
            clear_parse_state();
        end
        else begin
            lag_bytes[1] = lag_bytes[0];
            lag_bytes[0] = b;
            if (frame_pos < FRAME_CAP) frame_pos = frame_pos + 1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h expected %h",
                                      results_seen, name, got, want));
    endtask

    // Frame building on frame_buf.
    task automatic fill_random_bytes(input int n);
        frame_buf.delete();
        repeat (n) frame_buf.push_back(8'($urandom_range(255)));
    endtask

    // Writes the Fletcher sums over bytes 2 to L-3 into the last two bytes.
    task automatic seal_checksum();
        logic [7:0] a;
        logic [7:0] b;
        a = '0;
        b = '0;
        for (int i = 2; i < frame_buf.size() - 2; i++) begin
            a = a + frame_buf[i];
            b = b + a;
        end
        frame_buf[frame_buf.size() - 2] = a;
        frame_buf[frame_buf.size() - 1] = b;
    endtask

    task automatic build_posllh();
        bit nav;
        nav = ($urandom_range(3) != 0);
        fill_random_bytes(36);
        frame_buf[0] = SYNC_1;
        frame_buf[1] = SYNC_2;
        if (nav) begin
            frame_buf[2] = CLS_NAV;
            frame_buf[3] = ID_POSLLH;
            frame_buf[4] = POSLLH_LEN;
            frame_buf[5] = 8'h00;
        end
        seal_checksum();
    endtask

    task automatic queue_frame(input bit hold);
        byte_beat_t beat;
        foreach (frame_buf[i]) begin
            beat.rx_byte   = frame_buf[i];
            beat.frame_end = (i == frame_buf.size() - 1);
            beat.hold      = hold && (i == 0);
            tx_q.push_back(beat);
        end
    endtask

    task automatic build_stimulus();
        int frames;
        int kind;
        int pick;
        // Short frames: one, two and three bytes, which can never pass.
        frame_buf = '{SYNC_1};
        queue_frame(1'b0);
        frame_buf = '{SYNC_1, SYNC_2};
        queue_frame(1'b0);
        frame_buf = '{SYNC_1, SYNC_2, CLS_NAV};
        queue_frame(1'b0);
        // Four-byte frames compare bytes 2 and 3 with zero sums.
        frame_buf = '{SYNC_1, SYNC_2, 8'h00, 8'h00};
        queue_frame(1'b0);
        frame_buf = '{SYNC_1, SYNC_2, CLS_NAV, ID_POSLLH};
        queue_frame(1'b0);
        // All-ones frame that stops inside the first word.
        frame_buf = '{10{8'hFF}};
        seal_checksum();
        queue_frame(1'b0);

        frames = 0;
        while (tx_q.size() < RANDOM_BYTES || frames < MIN_FRAMES) begin
            kind = $urandom_range(99);
            if (frames == 20) begin
                // Long frame: the byte count saturates while summing goes on.
                fill_random_bytes($urandom_range(FRAME_CAP + 1, FRAME_CAP + 45));
                frame_buf[0] = SYNC_1;
                frame_buf[1] = SYNC_2;
                seal_checksum();
            end
            else if (kind < 70) begin
                build_posllh();
                if ($urandom_range(7) == 0) begin
                    pick = $urandom_range(frame_buf.size() - 1);
                    frame_buf[pick][$urandom_range(7)] ^= 1'b1;
                end
            end
            else if (kind < 85) begin
                fill_random_bytes($urandom_range(4, 40));
                if ($urandom_range(1) == 1) seal_checksum();
            end
            else begin
                fill_random_bytes($urandom_range(1, 40));
            end
            queue_frame(frames % 10 == 0);
            frames = frames + 1;
        end
    endtask

    // Byte driver.
    always @(posedge clk or negedge rst_n) begin
        bit present;
        if (!rst_n) begin
            frame.valid     <= 1'b0;
            frame.rx_byte   <= '0;
            frame.frame_end <= 1'b0;
            bytes_sent      <= 0;
            traffic_phase   <= 0;
        end
        else begin
            if (frame.valid && frame.ready) begin
                parse_byte(frame.rx_byte, frame.frame_end);
                void'(tx_q.pop_front());
                bytes_sent    <= bytes_sent + 1;
                traffic_phase <= ((bytes_sent + 1) / PHASE_BYTES) % 4;
            end
            if (!frame.valid || frame.ready) begin
                present = 1'b0;
                if (tx_q.size() != 0) begin
                    if (tx_q[0].hold && results_seen != results_predicted)
                        present = 1'b0;
                    else
                        present = ($urandom_range(99) >= src_idle_pct(traffic_phase));
                end
                frame.valid <= present;
                if (present) begin
                    frame.rx_byte   <= tx_q[0].rx_byte;
                    frame.frame_end <= tx_q[0].frame_end;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n) begin
        posllh_t want;
        if (!rst_n) begin
            result.ready <= 1'b0;
            results_seen <= 0;
        end
        else begin
            if (result.valid && result.ready) begin
                if (posllh_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end
                else begin
                    want = posllh_expected_q.pop_front();
                    compare_field("checksum_ok", result.checksum_ok, want.checksum_ok);
                    compare_field("msg_class", result.msg_class, want.msg_class);
                    compare_field("msg_id", result.msg_id, want.msg_id);
                    compare_field("payload_length", result.payload_length,
                                  want.payload_length);
                    compare_field("time_of_week_ms", result.time_of_week_ms,
                                  want.time_of_week_ms);
                    compare_field("longitude", result.longitude, want.longitude);
                    compare_field("latitude", result.latitude, want.latitude);
                    compare_field("ellipsoid_height", result.ellipsoid_height,
                                  want.ellipsoid_height);
                    compare_field("sea_level_height", result.sea_level_height,
                                  want.sea_level_height);
                    compare_field("horiz_accuracy", result.horiz_accuracy,
                                  want.horiz_accuracy);
                    compare_field("vert_accuracy", result.vert_accuracy,
                                  want.vert_accuracy);
                end
                results_seen <= results_seen + 1;
            end
            result.ready <= ($urandom_range(99) >= sink_stall_pct(traffic_phase));
        end
    end

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Ends the run when neither side has moved a beat for too long.
    initial begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(negedge clk);
            if ((frame.valid && frame.ready) || (result.valid && result.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("ubx_posllh_frame_parser_tb failed");
        $finish;
    end

    initial begin
        rst_n             = 1'b0;
        frame.valid       = 1'b0;
        frame.rx_byte     = '0;
        frame.frame_end   = 1'b0;
        result.ready      = 1'b0;
        mismatches        = 0;
        results_predicted = 0;
        clear_parse_state();
        build_stimulus();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        do @(negedge clk);
        while (tx_q.size() != 0 || results_seen != results_predicted);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (posllh_expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", posllh_expected_q.size()));
        if (mismatches == 0)
            $display("ubx_posllh_frame_parser_tb passed");
        else
            $display("ubx_posllh_frame_parser_tb failed");
        $finish;
    end

endmodule
